@@ hdl/sku_pkg.sv @@
// shared types and constants for the session key unwrap block
`default_nettype none

package sku_pkg;

  // message size bound and derived key length limit
  localparam int MAX_MSG_BYTES = 512;
  localparam int KEY_LIMIT     = MAX_MSG_BYTES - 13;

  // padding constants
  localparam logic [7:0] LEAD_BYTE = 8'h02;
  localparam logic [7:0] SEP_BYTE  = 8'h00;
  localparam logic [3:0] MIN_PAD   = 4'd8;
  localparam logic [3:0] PAD_SAT   = 4'd15;
  localparam logic [1:0] HOLD_FULL = 2'd2;

  // final status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_WRONG_KEY = 1'b1;

  // output queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KEY_LEN_W = 10;

  // message parse phase
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_PAD,
    PH_ALGO,
    PH_KEY
  } phase_t;

  // one result item
  typedef struct packed {
    logic                 is_final;
    logic [7:0]           key_byte;
    logic                 status;
    logic [7:0]           sym_algo;
    logic [KEY_LEN_W-1:0] key_length;
  } result_t;

  // results produced by one accepted byte, key byte result ahead of final
  typedef struct packed {
    logic    key;
    logic    fin;
    result_t key_res;
    result_t fin_res;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/sku_core.sv @@
// padding parser, key byte release and checksum check
`default_nettype none

module sku_core import sku_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] msg_byte,
  input  wire logic       last_byte,
  output push_t           push
);

  localparam logic [KEY_LEN_W-1:0] KEY_LIMIT_C = KEY_LIMIT[KEY_LEN_W-1:0];

  phase_t               phase, phase_next;
  logic [3:0]           pad_count, pad_count_next;
  logic [7:0]           held0, held0_next;
  logic [7:0]           held1, held1_next;
  logic [1:0]           held_count, held_count_next;
  logic [KEY_LEN_W-1:0] released_count, released_count_next;
  logic [15:0]          running_sum, running_sum_next;
  logic [7:0]           algo_byte, algo_byte_next;
  logic                 failed, failed_next;
  logic                 release_key;
  logic                 sum_ok;

  // next state for one byte, before end-of-message handling
  always_comb begin
    phase_next          = phase;
    pad_count_next      = pad_count;
    held0_next          = held0;
    held1_next          = held1;
    held_count_next     = held_count;
    released_count_next = released_count;
    running_sum_next    = running_sum;
    algo_byte_next      = algo_byte;
    failed_next         = failed;
    release_key         = 1'b0;
    if (!failed) begin
      case (phase)
        PH_LEAD: begin
          if (msg_byte == LEAD_BYTE) phase_next = PH_PAD;
          else failed_next = 1'b1;
        end
        PH_PAD: begin
          if (msg_byte != SEP_BYTE) begin
            if (pad_count < PAD_SAT) pad_count_next = pad_count + 4'd1;
          end else if (pad_count < MIN_PAD) begin
            failed_next = 1'b1;
          end else begin
            phase_next = PH_ALGO;
          end
        end
        PH_ALGO: begin
          algo_byte_next = msg_byte;
          phase_next     = PH_KEY;
        end
        PH_KEY: begin
          if (held_count >= HOLD_FULL) begin
            if (released_count >= KEY_LIMIT_C) begin
              failed_next = 1'b1;
            end else begin
              release_key         = 1'b1;
              running_sum_next    = running_sum + {8'd0, held0};
              released_count_next = released_count + KEY_LEN_W'(1);
            end
          end else begin
            held_count_next = held_count + 2'd1;
          end
          held0_next = held1;
          held1_next = msg_byte;
        end
        default: failed_next = 1'b1;
      endcase
    end
  end

  // checksum compare against state after this byte
  assign sum_ok = !failed_next && (phase_next == PH_KEY) && (held_count_next >= HOLD_FULL)
                  && ({held0_next, held1_next} == running_sum_next);

  // result items for this byte
  always_comb begin
    push                     = '0;
    push.key                 = take && release_key;
    push.key_res.is_final    = 1'b0;
    push.key_res.key_byte    = held0;
    push.fin                 = take && last_byte;
    push.fin_res.is_final    = 1'b1;
    if (sum_ok) begin
      push.fin_res.status      = STATUS_OK;
      push.fin_res.sym_algo    = algo_byte_next;
      push.fin_res.key_length  = released_count_next;
    end else begin
      push.fin_res.status      = STATUS_WRONG_KEY;
    end
  end

  // state registers, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase          <= PH_LEAD;
      pad_count      <= '0;
      held0          <= '0;
      held1          <= '0;
      held_count     <= '0;
      released_count <= '0;
      running_sum    <= '0;
      algo_byte      <= '0;
      failed         <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      pad_count      <= pad_count_next;
      held0          <= held0_next;
      held1          <= held1_next;
      held_count     <= held_count_next;
      released_count <= released_count_next;
      running_sum    <= running_sum_next;
      algo_byte      <= algo_byte_next;
      failed         <= failed_next;
    end
  end

  // checks
  a_fail_no_key: assert property (@(posedge clk) disable iff (rst)
    failed |-> !push.key) else $error("key byte released after failure");
  a_key_needs_hold: assert property (@(posedge clk) disable iff (rst)
    push.key |-> (phase == PH_KEY && held_count == HOLD_FULL))
    else $error("key byte released without two held bytes");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (take && last_byte) |=> (phase == PH_LEAD && !failed && released_count == '0))
    else $error("state not cleared after final byte");
  a_ok_has_key_phase: assert property (@(posedge clk) disable iff (rst)
    (push.fin && push.fin_res.status == STATUS_OK) |-> (phase == PH_KEY || phase == PH_ALGO))
    else $error("ok status outside key phase");

endmodule

`default_nettype wire

@@ hdl/sku_out_queue.sv @@
// small result queue taking up to two results per cycle
`default_nettype none

module sku_out_queue import sku_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   head
);

  localparam logic [QCNT_W-1:0] DEPTH_C = QUEUE_DEPTH[QCNT_W-1:0];

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;
  logic [1:0]        push_n;
  result_t           first_res;

  // room for the worst case of two results
  assign space     = count <= (DEPTH_C - QCNT_W'(2));
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = {1'b0, push.key} + {1'b0, push.fin};
  assign first_res = push.key ? push.key_res : push.fin_res;
  assign count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);

  // payload storage
  always_ff @(posedge clk) begin
    if (push.key || push.fin) entries[wr_ptr] <= first_res;
    if (push.key && push.fin) entries[wr_ptr + QPTR_W'(1)] <= push.fin_res;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count  <= count_next;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.key || push.fin) |-> (count <= DEPTH_C - QCNT_W'(push_n)))
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("result queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (!push.key && !push.fin && pop) |=> (count == $past(count) - QCNT_W'(1)))
    else $error("result queue count lost a pop");

endmodule

`default_nettype wire

@@ hdl/pkcs1_session_key_unwrap_unit.sv @@
// top level of the session key unwrap block
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, msg_byte, last_byte          | in
//  out     | out_valid, out_ready, is_final, key_byte, status, | out
//          | sym_algo, key_length                             |
//
// one message byte is taken per cycle; its results are written to a
// four-entry result queue, which sets the input stall: in_ready drops
// while fewer than two queue slots are free. a final byte that also
// releases a key byte yields two results, drained one per cycle while
// out_ready is high. synchronous reset clears parser and queue.
`default_nettype none

module pkcs1_session_key_unwrap_unit import sku_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           msg_byte,
  input  wire logic                 last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      is_final,
  output logic [7:0]                key_byte,
  output logic                      status,
  output logic [7:0]                sym_algo,
  output logic [KEY_LEN_W-1:0]      key_length
);

  push_t   push;
  logic    space;
  logic    take;
  result_t head;

  // input transaction
  assign in_ready = space;
  assign take     = in_valid && in_ready;

  sku_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .msg_byte  (msg_byte),
    .last_byte (last_byte),
    .push      (push)
  );

  sku_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // output payload
  assign is_final    = head.is_final;
  assign key_byte    = head.key_byte;
  assign status      = head.status;
  assign sym_algo    = head.sym_algo;
  assign key_length  = head.key_length;

endmodule

`default_nettype wire
